// File: design/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and codes of the k-way merge min-select block.
// ----------------------------------------------------------------------------
package kwm_pkg;

	localparam int CFG_BITS       = 11;
	localparam int BATCH_CNT_BITS = 10;
	localparam int BLOCK_MAX      = 1024;

	localparam logic [1:0] STAT_LOAD_OK   = 2'd0;
	localparam logic [1:0] STAT_LOAD_REJ  = 2'd1;
	localparam logic [1:0] STAT_REC_OUT   = 2'd2;
	localparam logic [1:0] STAT_ALL_EMPTY = 2'd3;

	localparam logic REQ_LOAD    = 1'b0;
	localparam logic REQ_EXTRACT = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [2:0]  way;
		logic [63:0] key;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] out_key;
		logic [2:0]  out_way;
		logic        refill_needed;
		logic        batch_last;
	} out_beat_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_LOAD,
		CS_SCAN,
		CS_FLUSH,
		CS_POP,
		CS_EMIT
	} ctl_state_t;

	typedef struct packed {
		logic accept;
		logic do_load;
		logic scan_issue;
		logic do_pop;
		logic emit;
	} dp_cmd_t;

endpackage

// File: design/kwm_ctrl.sv
// ----------------------------------------------------------------------------
// kwm_ctrl
// Sequencer: takes one beat, runs the load or the head scan, then hands the
// result to the output register.
// ----------------------------------------------------------------------------
module kwm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_type,
	output logic            req_stall,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	input  logic            scan_last,
	output kwm_pkg::dp_cmd_t cmd
);
	import kwm_pkg::*;

	ctl_state_t state_q, state_d;
	logic       rsp_valid_q;
	logic       out_free;

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (req_valid) begin
					state_d = (req_type == REQ_EXTRACT) ? CS_SCAN : CS_LOAD;
				end
			end
			CS_LOAD:  state_d = CS_EMIT;
			CS_SCAN: begin
				if (scan_last) begin
					state_d = CS_FLUSH;
				end
			end
			CS_FLUSH: state_d = CS_POP;
			CS_POP:   state_d = CS_EMIT;
			CS_EMIT: begin
				if (out_free) begin
					state_d = CS_IDLE;
				end
			end
			default:  state_d = CS_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			CS_IDLE: begin
				req_stall  = 1'b0;
				cmd.accept = req_valid;
			end
			CS_LOAD:  cmd.do_load    = 1'b1;
			CS_SCAN:  cmd.scan_issue = 1'b1;
			CS_FLUSH: cmd            = '0;
			CS_POP:   cmd.do_pop     = 1'b1;
			CS_EMIT:  cmd.emit       = out_free;
			default:  cmd            = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// File: design/kwm_dpath.sv
// ----------------------------------------------------------------------------
// kwm_dpath
// Way fifos in one key memory, per-way pointers and fill counts, the serial
// min compare, batch counter and result registers.
// ----------------------------------------------------------------------------
module kwm_dpath #(
	parameter int WAYS      = 8,
	parameter int WAY_DEPTH = 16,
	parameter int KEY_BITS  = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  kwm_pkg::in_beat_t              req,
	input  kwm_pkg::dp_cmd_t               cmd,
	input  logic                           cfg_we,
	input  logic [kwm_pkg::CFG_BITS-1:0]   cfg_wdata,
	output logic                           scan_last,
	output kwm_pkg::out_beat_t             rsp
);
	import kwm_pkg::*;

	localparam int WIDX      = $clog2(WAYS);
	localparam int PW        = (WAY_DEPTH > 1) ? $clog2(WAY_DEPTH) : 1;
	localparam int FW        = $clog2(WAY_DEPTH + 1);
	localparam int AW        = WIDX + PW;
	localparam int MEM_DEPTH = 1 << AW;

	function automatic logic [PW-1:0] nxt_ptr(input logic [PW-1:0] p);
		return (p == PW'(WAY_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	in_beat_t                req_q;
	logic [WIDX-1:0]         scan_cnt_q;
	logic [WIDX-1:0]         idx;
	logic [FW-1:0]           fill_q   [WAYS];
	logic [PW-1:0]           rd_ptr_q [WAYS];
	logic [PW-1:0]           wr_ptr_q [WAYS];
	logic [KEY_BITS-1:0]     mem      [MEM_DEPTH];
	logic [KEY_BITS-1:0]     rd_data_s1;
	logic                    cmp_vld_s1;
	logic                    cmp_ne_s1;
	logic [WIDX-1:0]         cmp_idx_s1;
	logic                    best_found_q;
	logic [KEY_BITS-1:0]     best_key_q;
	logic [WIDX-1:0]         best_idx_q;
	logic [BATCH_CNT_BITS-1:0] batch_cnt_q, batch_cnt_d;
	logic [CFG_BITS-1:0]     brec_q;
	logic [CFG_BITS-1:0]     bsize;
	logic [FW-1:0]           fill_cur;
	logic                    way_ok;
	logic                    load_ok;
	out_beat_t               res_d, res_q, rsp_q;

	always_comb begin
		if (cmd.scan_issue) begin
			idx = scan_cnt_q;
		end else if (cmd.do_pop) begin
			idx = best_idx_q;
		end else begin
			idx = WIDX'(req_q.way);
		end
	end

	assign fill_cur  = fill_q[idx];
	assign way_ok    = int'(req_q.way) < WAYS;
	assign load_ok   = way_ok && (fill_cur < FW'(WAY_DEPTH));
	assign scan_last = (scan_cnt_q == WIDX'(WAYS - 1));

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req;
		end
	end

	// key memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.do_load && load_ok) begin
			mem[{idx, wr_ptr_q[idx]}] <= req_q.key[KEY_BITS-1:0];
		end
		rd_data_s1 <= mem[{idx, rd_ptr_q[idx]}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WAYS; i++) begin
				fill_q[i]   <= '0;
				rd_ptr_q[i] <= '0;
				wr_ptr_q[i] <= '0;
			end
		end else if (cmd.do_load && load_ok) begin
			wr_ptr_q[idx] <= nxt_ptr(wr_ptr_q[idx]);
			fill_q[idx]   <= fill_cur + 1'b1;
		end else if (cmd.do_pop && best_found_q) begin
			rd_ptr_q[idx] <= nxt_ptr(rd_ptr_q[idx]);
			fill_q[idx]   <= fill_cur - 1'b1;
		end
	end

	// serial min compare, one head per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q   <= '0;
			cmp_vld_s1   <= 1'b0;
			cmp_ne_s1    <= 1'b0;
			cmp_idx_s1   <= '0;
			best_found_q <= 1'b0;
			best_key_q   <= '0;
			best_idx_q   <= '0;
		end else begin
			cmp_vld_s1 <= cmd.scan_issue;
			cmp_ne_s1  <= (fill_cur != '0);
			cmp_idx_s1 <= idx;
			if (cmd.accept) begin
				scan_cnt_q   <= '0;
				best_found_q <= 1'b0;
			end else begin
				if (cmd.scan_issue) begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
				end
				if (cmp_vld_s1 && cmp_ne_s1 &&
				    (!best_found_q || (rd_data_s1 < best_key_q))) begin
					best_found_q <= 1'b1;
					best_key_q   <= rd_data_s1;
					best_idx_q   <= cmp_idx_s1;
				end
			end
		end
	end

	always_comb begin
		if (brec_q == '0) begin
			bsize = CFG_BITS'(1);
		end else if (brec_q > CFG_BITS'(BLOCK_MAX)) begin
			bsize = CFG_BITS'(BLOCK_MAX);
		end else begin
			bsize = brec_q;
		end
	end

	always_comb begin
		res_d       = '0;
		batch_cnt_d = batch_cnt_q;
		if (cmd.do_load) begin
			res_d.status = load_ok ? STAT_LOAD_OK : STAT_LOAD_REJ;
		end else if (best_found_q) begin
			res_d.status        = STAT_REC_OUT;
			res_d.out_key       = 64'(best_key_q);
			res_d.out_way       = 3'(best_idx_q);
			res_d.refill_needed = (fill_cur == FW'(1));
			if ((CFG_BITS'(batch_cnt_q) + CFG_BITS'(1)) >= bsize) begin
				res_d.batch_last = 1'b1;
				batch_cnt_d      = '0;
			end else begin
				batch_cnt_d = batch_cnt_q + 1'b1;
			end
		end else begin
			res_d.status     = STAT_ALL_EMPTY;
			res_d.batch_last = (batch_cnt_q != '0);
			batch_cnt_d      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			batch_cnt_q <= '0;
			brec_q      <= CFG_BITS'(1);
		end else begin
			if (cmd.do_pop) begin
				batch_cnt_q <= batch_cnt_d;
			end
			if (cfg_we) begin
				brec_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_load || cmd.do_pop) begin
			res_q <= res_d;
		end
		if (cmd.emit) begin
			rsp_q <= res_q;
		end
	end

	assign rsp = rsp_q;

endmodule

// File: design/kway_merge_min_select.sv
// ----------------------------------------------------------------------------
// kway_merge_min_select
// K-way merge of presorted runs with a serial min scan over the way heads.
// ----------------------------------------------------------------------------
// One beat is taken at a time and gives one result beat. A load takes the
// beat and stores the key if it is accepted; an extract takes the beat, runs
// the head scan that reads one way head a cycle through the single read port
// of the key memory into one comparator, finishes the last compare and pops.
// Both hand off to the output register, and the hand-off waits while the
// previous result is still stalled. A result waiting in the output register
// does not hold off the next request beat. The user must write block_records
// only while the block is idle; the block itself does not enforce it.
module kway_merge_min_select #(
	parameter int WAYS      = 8,
	parameter int WAY_DEPTH = 16,
	parameter int KEY_BITS  = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  kwm_pkg::in_beat_t            req,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output kwm_pkg::out_beat_t           rsp,
	input  logic                         block_records_we,
	input  logic [kwm_pkg::CFG_BITS-1:0] block_records_wdata
);
	import kwm_pkg::*;

	dp_cmd_t cmd;
	logic    scan_last;

	kwm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.scan_last (scan_last),
		.cmd       (cmd)
	);

	kwm_dpath #(
		.WAYS      (WAYS),
		.WAY_DEPTH (WAY_DEPTH),
		.KEY_BITS  (KEY_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cfg_we    (block_records_we),
		.cfg_wdata (block_records_wdata),
		.scan_last (scan_last),
		.rsp       (rsp)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request side open right after an accepted beat");

	a_refill_only_on_record: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.refill_needed |-> rsp.status == STAT_REC_OUT)
		else $error("refill flagged on a non-record beat");

	a_no_last_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == STAT_LOAD_OK || rsp.status == STAT_LOAD_REJ)
		|-> !rsp.batch_last)
		else $error("batch closed by a load beat");

endmodule
